>>> design/rrep_pkg.sv
package rrep_pkg;

    // Field widths of the stream and register payloads.
    localparam int COORD_W = 24;
    localparam int DIR_W   = 16;
    localparam int HALF_W  = 23;

    // Internal arithmetic widths.
    localparam int DIFF_W = COORD_W + 1;          // face coordinate minus start
    localparam int PROD_W = DIFF_W + DIR_W;       // direction times difference
    localparam int NUM_W  = PROD_W - 1;           // rounded dividend magnitude
    localparam int DEN_W  = DIR_W;                // divisor magnitude
    localparam int REM_W  = DEN_W + 1;            // trial remainder
    localparam int SUM_W  = NUM_W + 2;            // signed quotient plus base

    // Pipeline shape.
    localparam int LANES          = 2;            // lane 0: side face, lane 1: top or bottom
    localparam int FRONT_STAGES   = 3;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = NUM_W / BITS_PER_STAGE;
    localparam int BACK_STAGES    = 2;
    localparam int PIPE_STAGES    = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_HALF_WIDTH  = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;

    // Crossed face codes.
    typedef enum logic [1:0] {
        FACE_RIGHT  = 2'd0,
        FACE_LEFT   = 2'd1,
        FACE_TOP    = 2'd2,
        FACE_BOTTOM = 2'd3
    } face_t;

    // Values that travel alongside the two divisions.
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      dx_neg;
        logic                      dy_neg;
        logic [LANES-1:0]          q_neg;
    } side_t;

endpackage

>>> design/ray_rect_exit_point_unit.sv
// Channel   Direction  Contents
// s_*       in         ray beats: start point and direction
// m_*       out        exit point beats: hit point, face, saturation flag
// p*        in/out     APB register port: half_width at 0x0, half_height at 0x4
//
// One beat is accepted per cycle while no stall holds the pipeline: the two
// 40-bit divisions run as ten stages of four quotient bits each, between a
// three-stage front end and a two-stage back end.
// Reset clears the valid bits and loads the default half extents.
// Each stage holds its beat while the stage after it is full and stalled, so
// bubbles close up and an output stall reaches the input only when every stage is full.
module ray_rect_exit_point_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [79:0]                   s_tdata,   // start_x, start_y, dir_x, dir_y
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // hit_x, hit_y
    output logic [2:0]                    m_tuser,   // face, saturated
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrep_pkg::ADDR_W-1:0]   paddr,
    input  logic [rrep_pkg::DATA_W-1:0]   pwdata,
    output logic [rrep_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int N = rrep_pkg::PIPE_STAGES;
    localparam int F = rrep_pkg::FRONT_STAGES;
    localparam int D = rrep_pkg::DIV_STAGES;

    logic [rrep_pkg::HALF_W-1:0] half_width_reg, half_height_reg;
    logic [N-1:0]                valid_reg, valid_next, en;

    logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] num, quot;
    logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] den;
    rrep_pkg::side_t                                 side_front, side_div;

    logic signed [rrep_pkg::COORD_W-1:0] hit_x, hit_y;
    rrep_pkg::face_t                     face;
    logic                                saturated;

    // Register writes and reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= rrep_pkg::HALF_W'(38400);
            half_height_reg <= rrep_pkg::HALF_W'(25600);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == rrep_pkg::REG_HALF_WIDTH)
            begin
                half_width_reg <= pwdata[rrep_pkg::HALF_W-1:0];
            end
            else
            begin
                half_height_reg <= pwdata[rrep_pkg::HALF_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rrep_pkg::REG_HALF_WIDTH)
                  ? rrep_pkg::DATA_W'(half_width_reg)
                  : rrep_pkg::DATA_W'(half_height_reg);

    // A stage may load when it is empty or its contents move on.
    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || m_tready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < N; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[N-1];

    rrep_front u_front (
        .clk         (clk),
        .en          (en[F-1:0]),
        .start_x     (s_tdata[23:0]),
        .start_y     (s_tdata[47:24]),
        .dir_x       (s_tdata[63:48]),
        .dir_y       (s_tdata[79:64]),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .num         (num),
        .den         (den),
        .side        (side_front)
    );

    rrep_div u_div (
        .clk      (clk),
        .en       (en[F+D-1:F]),
        .in_num   (num),
        .in_den   (den),
        .in_side  (side_front),
        .quot     (quot),
        .out_side (side_div)
    );

    rrep_back u_back (
        .clk         (clk),
        .en          (en[N-1:F+D]),
        .quot        (quot),
        .side        (side_div),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .hit_x       (hit_x),
        .hit_y       (hit_y),
        .face        (face),
        .saturated   (saturated)
    );

    assign m_tdata = {hit_y, hit_x};
    assign m_tuser = {saturated, face};

endmodule

>>> design/rrep_front.sv
// Front end: direction clean-up, face differences, products and rounded
// dividend magnitudes, three register stages.
module rrep_front (
    input  logic                                           clk,
    input  logic [rrep_pkg::FRONT_STAGES-1:0]              en,
    input  logic signed [rrep_pkg::COORD_W-1:0]            start_x,
    input  logic signed [rrep_pkg::COORD_W-1:0]            start_y,
    input  logic signed [rrep_pkg::DIR_W-1:0]              dir_x,
    input  logic signed [rrep_pkg::DIR_W-1:0]              dir_y,
    input  logic [rrep_pkg::HALF_W-1:0]                    half_width,
    input  logic [rrep_pkg::HALF_W-1:0]                    half_height,
    output logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] num,
    output logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] den,
    output rrep_pkg::side_t                                side
);

    // Stage 0 registers.
    logic signed [rrep_pkg::COORD_W-1:0] sx0_reg, sy0_reg;
    logic signed [rrep_pkg::DIR_W-1:0]   dxs0_reg, dys0_reg;
    logic [rrep_pkg::DEN_W-1:0]          adx0_reg, ady0_reg;
    logic                                dxn0_reg, dyn0_reg;
    logic signed [rrep_pkg::DIFF_W-1:0]  diffx0_reg, diffy0_reg;

    // Stage 1 registers.
    logic signed [rrep_pkg::COORD_W-1:0] sx1_reg, sy1_reg;
    logic [rrep_pkg::DEN_W-1:0]          adx1_reg, ady1_reg;
    logic                                dxn1_reg, dyn1_reg;
    logic signed [rrep_pkg::PROD_W-1:0]  p1_reg, p2_reg;

    // Stage 2 registers.
    logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] num_reg;
    logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] den_reg;
    rrep_pkg::side_t                                 side_reg;

    logic signed [rrep_pkg::DIR_W-1:0]   dxs0_next, dys0_next;
    logic [rrep_pkg::DEN_W-1:0]          adx0_next, ady0_next;
    logic signed [rrep_pkg::COORD_W-1:0] fx, fy;
    logic signed [rrep_pkg::DIFF_W-1:0]  diffx0_next, diffy0_next;
    logic signed [rrep_pkg::PROD_W-1:0]  p1_next, p2_next;
    logic [rrep_pkg::PROD_W-1:0]         ap1, ap2;

    // A zero component becomes the smallest positive step; the face is picked by sign.
    always_comb
    begin
        dxs0_next = (dir_x == '0) ? rrep_pkg::DIR_W'(1) : dir_x;
        dys0_next = (dir_y == '0) ? rrep_pkg::DIR_W'(1) : dir_y;
        adx0_next = dir_x[rrep_pkg::DIR_W-1] ? (~dir_x + rrep_pkg::DEN_W'(1)) : dxs0_next;
        ady0_next = dir_y[rrep_pkg::DIR_W-1] ? (~dir_y + rrep_pkg::DEN_W'(1)) : dys0_next;
        fx = dir_x[rrep_pkg::DIR_W-1] ? (rrep_pkg::COORD_W'(0) - {1'b0, half_width})
                                      : {1'b0, half_width};
        fy = dir_y[rrep_pkg::DIR_W-1] ? (rrep_pkg::COORD_W'(0) - {1'b0, half_height})
                                      : {1'b0, half_height};
        diffx0_next = {fx[rrep_pkg::COORD_W-1], fx} - {start_x[rrep_pkg::COORD_W-1], start_x};
        diffy0_next = {fy[rrep_pkg::COORD_W-1], fy} - {start_y[rrep_pkg::COORD_W-1], start_y};
    end

    // Products of the cross direction with the face distances.
    always_comb
    begin
        p1_next = rrep_pkg::PROD_W'(dys0_reg) * rrep_pkg::PROD_W'(diffx0_reg);
        p2_next = rrep_pkg::PROD_W'(dxs0_reg) * rrep_pkg::PROD_W'(diffy0_reg);
        ap1 = p1_reg[rrep_pkg::PROD_W-1] ? (rrep_pkg::PROD_W'(0) - p1_reg) : p1_reg;
        ap2 = p2_reg[rrep_pkg::PROD_W-1] ? (rrep_pkg::PROD_W'(0) - p2_reg) : p2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sx0_reg    <= start_x;
            sy0_reg    <= start_y;
            dxs0_reg   <= dxs0_next;
            dys0_reg   <= dys0_next;
            adx0_reg   <= adx0_next;
            ady0_reg   <= ady0_next;
            dxn0_reg   <= dir_x[rrep_pkg::DIR_W-1];
            dyn0_reg   <= dir_y[rrep_pkg::DIR_W-1];
            diffx0_reg <= diffx0_next;
            diffy0_reg <= diffy0_next;
        end
        if (en[1])
        begin
            sx1_reg  <= sx0_reg;
            sy1_reg  <= sy0_reg;
            adx1_reg <= adx0_reg;
            ady1_reg <= ady0_reg;
            dxn1_reg <= dxn0_reg;
            dyn1_reg <= dyn0_reg;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
        end
        // Half the divisor is added so that truncating division rounds to nearest.
        if (en[2])
        begin
            num_reg[0] <= ap1[rrep_pkg::NUM_W-1:0] + rrep_pkg::NUM_W'(adx1_reg >> 1);
            num_reg[1] <= ap2[rrep_pkg::NUM_W-1:0] + rrep_pkg::NUM_W'(ady1_reg >> 1);
            den_reg[0] <= adx1_reg;
            den_reg[1] <= ady1_reg;
            side_reg.sx       <= sx1_reg;
            side_reg.sy       <= sy1_reg;
            side_reg.dx_neg   <= dxn1_reg;
            side_reg.dy_neg   <= dyn1_reg;
            side_reg.q_neg[0] <= p1_reg[rrep_pkg::PROD_W-1] ^ dxn1_reg;
            side_reg.q_neg[1] <= p2_reg[rrep_pkg::PROD_W-1] ^ dyn1_reg;
        end
    end

    assign num  = num_reg;
    assign den  = den_reg;
    assign side = side_reg;

endmodule

>>> design/rrep_div.sv
// Pipelined restoring divider for both lanes, four quotient bits per stage.
module rrep_div (
    input  logic                                            clk,
    input  logic [rrep_pkg::DIV_STAGES-1:0]                 en,
    input  logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] in_num,
    input  logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] in_den,
    input  rrep_pkg::side_t                                 in_side,
    output logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] quot,
    output rrep_pkg::side_t                                 out_side
);

    // Per stage: dividend bits shifting out at the top, quotient bits shifting in below.
    logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] nq_reg  [rrep_pkg::DIV_STAGES];
    logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] rem_reg [rrep_pkg::DIV_STAGES];
    logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] den_reg [rrep_pkg::DIV_STAGES];
    rrep_pkg::side_t                                 side_reg[rrep_pkg::DIV_STAGES];

    for (genvar g = 0; g < rrep_pkg::DIV_STAGES; g++)
    begin : g_stage
        logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] nq_in,  nq_next;
        logic [rrep_pkg::LANES-1:0][rrep_pkg::DEN_W-1:0] rem_in, rem_next, den_in;
        rrep_pkg::side_t                                 side_in;

        if (g == 0)
        begin : g_first
            assign nq_in   = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign nq_in   = nq_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // Shift, compare and subtract, once for each quotient bit of the stage.
        always_comb
        begin
            logic [rrep_pkg::NUM_W-1:0] nq;
            logic [rrep_pkg::REM_W-1:0] trial;
            logic [rrep_pkg::DEN_W-1:0] rem;
            for (int l = 0; l < rrep_pkg::LANES; l++)
            begin
                nq  = nq_in[l];
                rem = rem_in[l];
                for (int k = 0; k < rrep_pkg::BITS_PER_STAGE; k++)
                begin
                    trial = {rem, nq[rrep_pkg::NUM_W-1]};
                    nq    = {nq[rrep_pkg::NUM_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_in[l]})
                    begin
                        trial = trial - {1'b0, den_in[l]};
                        nq[0] = 1'b1;
                    end
                    rem = trial[rrep_pkg::DEN_W-1:0];
                end
                nq_next[l]  = nq;
                rem_next[l] = rem;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                nq_reg[g]   <= nq_next;
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_in;
                side_reg[g] <= side_in;
            end
        end
    end

    assign quot     = nq_reg[rrep_pkg::DIV_STAGES-1];
    assign out_side = side_reg[rrep_pkg::DIV_STAGES-1];

endmodule

>>> design/rrep_back.sv
// Back end: signed sums, side hit test, face choice and saturation.
module rrep_back (
    input  logic                                            clk,
    input  logic [rrep_pkg::BACK_STAGES-1:0]                en,
    input  logic [rrep_pkg::LANES-1:0][rrep_pkg::NUM_W-1:0] quot,
    input  rrep_pkg::side_t                                 side,
    input  logic [rrep_pkg::HALF_W-1:0]                     half_width,
    input  logic [rrep_pkg::HALF_W-1:0]                     half_height,
    output logic signed [rrep_pkg::COORD_W-1:0]             hit_x,
    output logic signed [rrep_pkg::COORD_W-1:0]             hit_y,
    output rrep_pkg::face_t                                 face,
    output logic                                            saturated
);

    localparam int EXT_W = rrep_pkg::SUM_W - rrep_pkg::COORD_W;
    localparam int PAD_W = rrep_pkg::SUM_W - rrep_pkg::HALF_W;

    logic signed [rrep_pkg::SUM_W-1:0]   sq0, sq1, hy_sum, hx_sum, hh_ext;
    logic                                side_ok_reg, dxn_reg, dyn_reg;
    logic signed [rrep_pkg::COORD_W-1:0] hy_reg;
    logic signed [rrep_pkg::SUM_W-1:0]   hx_reg;

    logic signed [rrep_pkg::COORD_W-1:0] hit_x_reg, hit_y_reg;
    rrep_pkg::face_t                     face_reg;
    logic                                sat_reg;

    logic [EXT_W:0]                      hx_top;
    logic                                hx_fits;

    // Apply the quotient signs and add the start coordinates.
    always_comb
    begin
        sq0 = side.q_neg[0] ? (rrep_pkg::SUM_W'(0) - {2'b00, quot[0]}) : {2'b00, quot[0]};
        sq1 = side.q_neg[1] ? (rrep_pkg::SUM_W'(0) - {2'b00, quot[1]}) : {2'b00, quot[1]};
        hy_sum = {{EXT_W{side.sy[rrep_pkg::COORD_W-1]}}, side.sy} + sq0;
        hx_sum = {{EXT_W{side.sx[rrep_pkg::COORD_W-1]}}, side.sx} + sq1;
        hh_ext = {{PAD_W{1'b0}}, half_height};
    end

    // The upper bits of the top or bottom hit must all match for it to fit.
    always_comb
    begin
        hx_top  = hx_reg[rrep_pkg::SUM_W-1:rrep_pkg::COORD_W-1];
        hx_fits = (&hx_top) || (~|hx_top);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_ok_reg <= (hy_sum <= hh_ext) && (hy_sum >= -hh_ext);
            hy_reg      <= hy_sum[rrep_pkg::COORD_W-1:0];
            hx_reg      <= hx_sum;
            dxn_reg     <= side.dx_neg;
            dyn_reg     <= side.dy_neg;
        end
        if (en[1])
        begin
            if (side_ok_reg)
            begin
                hit_x_reg <= dxn_reg ? (rrep_pkg::COORD_W'(0) - {1'b0, half_width})
                                     : {1'b0, half_width};
                hit_y_reg <= hy_reg;
                face_reg  <= dxn_reg ? rrep_pkg::FACE_LEFT : rrep_pkg::FACE_RIGHT;
                sat_reg   <= 1'b0;
            end
            else
            begin
                hit_y_reg <= dyn_reg ? (rrep_pkg::COORD_W'(0) - {1'b0, half_height})
                                     : {1'b0, half_height};
                face_reg  <= dyn_reg ? rrep_pkg::FACE_BOTTOM : rrep_pkg::FACE_TOP;
                sat_reg   <= !hx_fits;
                if (hx_fits)
                begin
                    hit_x_reg <= hx_reg[rrep_pkg::COORD_W-1:0];
                end
                else
                begin
                    hit_x_reg <= {hx_reg[rrep_pkg::SUM_W-1],
                                  {(rrep_pkg::COORD_W-1){!hx_reg[rrep_pkg::SUM_W-1]}}};
                end
            end
        end
    end

    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign face      = face_reg;
    assign saturated = sat_reg;

endmodule

>>> bench/ray_rect_exit_point_unit_tb.sv
`timescale 1ns / 1ps

module ray_rect_exit_point_unit_tb;

    localparam int LATENCY   = rrep_pkg::PIPE_STAGES;
    localparam int CYCLE_CAP = 400000;

    // Declared from the top bits down so that start_x lands in the lowest bits.
    typedef struct packed {
        logic signed [15:0] dy;
        logic signed [15:0] dx;
        logic signed [23:0] sy;
        logic signed [23:0] sx;
    } ray_t;

    typedef struct packed {
        logic signed [23:0] hx;
        logic signed [23:0] hy;
        rrep_pkg::face_t    face;
        logic               sat;
    } exit_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [79:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic [2:0] m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rrep_pkg::ADDR_W-1:0] paddr;
    logic [rrep_pkg::DATA_W-1:0] pwdata;
    logic [rrep_pkg::DATA_W-1:0] prdata;
    logic pready;

    ray_rect_exit_point_unit dut (.*);

    // Testbench copy of the configuration.
    logic [22:0] cur_hw;
    logic [22:0] cur_hh;

    ray_t  ray_queue[$];
    exit_t exit_queue[$];
    int    mismatches;
    int    cycles;
    bit    sender_paused;
    bit    calm_phase;
    int    hold_cycles;
    int    tx_gap;
    int    rx_gap;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Rounded division, ties away from zero.
    function automatic longint div_nearest(longint num, longint den);
        longint an;
        longint ad;
        longint q;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (an + ad / 2) / ad;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Exit point for one ray under the current half extents.
    function automatic exit_t exit_point(ray_t r);
        exit_t  e;
        longint sx;
        longint sy;
        longint dx;
        longint dy;
        longint hw;
        longint hh;
        longint fx;
        longint fy;
        longint y;
        longint x;
        sx = r.sx;
        sy = r.sy;
        dx = r.dx;
        dy = r.dy;
        hw = cur_hw;
        hh = cur_hh;
        if (dx == 0) dx = 1;
        if (dy == 0) dy = 1;
        fx = dx > 0 ? hw : -hw;
        y = sy + div_nearest(dy * (fx - sx), dx);
        e.sat = 1'b0;
        if (y <= hh && y >= -hh) begin
            e.hx = fx[23:0];
            e.hy = y[23:0];
            e.face = dx > 0 ? rrep_pkg::FACE_RIGHT : rrep_pkg::FACE_LEFT;
        end
        else begin
            fy = dy > 0 ? hh : -hh;
            e.face = dy > 0 ? rrep_pkg::FACE_TOP : rrep_pkg::FACE_BOTTOM;
            x = sx + div_nearest(dx * (fy - sy), dy);
            if (x > 8388607) begin
                x = 8388607;
                e.sat = 1'b1;
            end
            if (x < -8388608) begin
                x = -8388608;
                e.sat = 1'b1;
            end
            e.hx = x[23:0];
            e.hy = fy[23:0];
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic add_ray(logic [23:0] sx, logic [23:0] sy, logic [15:0] dx,
                           logic [15:0] dy);
        ray_t r;
        r.sx = sx;
        r.sy = sy;
        r.dx = dx;
        r.dy = dy;
        ray_queue.push_back(r);
    endtask

    // Random ray, mostly started inside the rectangle.
    task automatic add_random_ray();
        int kind;
        logic [23:0] sx;
        logic [23:0] sy;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            sx = 24'($urandom_range(0, 2 * cur_hw) - cur_hw);
            sy = 24'($urandom_range(0, 2 * cur_hh) - cur_hh);
        end
        else begin
            sx = 24'($urandom);
            sy = 24'($urandom);
        end
        case ($urandom_range(0, 5))
            0: add_ray(sx, sy, 16'd0, 16'($urandom));
            1: add_ray(sx, sy, 16'($urandom), 16'd0);
            2: add_ray(sx, sy, 16'($urandom_range(0, 3) - 1), 16'($urandom));
            default: add_ray(sx, sy, 16'($urandom), 16'($urandom));
        endcase
    endtask

    // Register write through the APB port while the pipeline is idle.
    task automatic write_reg(logic [rrep_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(4 * rrep_pkg::REG_HALF_WIDTH)) cur_hw = value[22:0];
        else cur_hh = value[22:0];
    endtask

    task automatic drain();
        wait (ray_queue.size() == 0 && exit_queue.size() == 0 && !s_tvalid);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Driver: offers pending rays with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                exit_queue.push_back(exit_point(ray_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (ray_queue.size() > 0 && !sender_paused)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= ray_queue.pop_front();
                    if (!calm_phase && $urandom_range(0, 5) == 0)
                        tx_gap <= $urandom_range(1, 4);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: random bursts, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 5) == 0)
                rx_gap <= $urandom_range(1, 4);
        end
    end

    // Monitor: compares each output beat with the oldest expectation.
    always @(posedge clk)
    begin
        exit_t want;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exit_queue.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                want = exit_queue.pop_front();
                if ($signed(m_tdata[23:0]) != want.hx)
                    report_mismatch("hit_x", $signed(m_tdata[23:0]), want.hx);
                if ($signed(m_tdata[47:24]) != want.hy)
                    report_mismatch("hit_y", $signed(m_tdata[47:24]), want.hy);
                if (m_tuser[1:0] != want.face)
                    report_mismatch("face", m_tuser[1:0], want.face);
                if (m_tuser[2] != want.sat)
                    report_mismatch("saturated", m_tuser[2], want.sat);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        sender_paused = 1'b0;
        calm_phase = 1'b0;
        hold_cycles = 0;
        cur_hw = 23'd38400;
        cur_hh = 23'd25600;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rays under the reset extents.
        add_ray(24'd0, 24'd0, 16'd100, 16'd10);
        add_ray(24'd0, 24'd0, -16'sd100, 16'd10);
        add_ray(24'd0, 24'd0, 16'd10, 16'd100);
        add_ray(24'd0, 24'd0, 16'd10, -16'sd100);
        add_ray(24'd0, 24'd0, 16'd0, 16'd5);
        add_ray(24'd0, 24'd0, 16'd5, 16'd0);
        add_ray(24'd0, 24'd0, 16'd0, 16'd0);
        add_ray(24'd0, 24'd0, 16'h7fff, 16'h8000);
        add_ray(24'd0, 24'd0, 16'h8000, 16'h7fff);
        add_ray(24'h7fffff, 24'h800000, 16'h8000, 16'h8000);
        add_ray(24'h800000, 24'h7fffff, 16'h7fff, 16'h7fff);
        add_ray(24'd38400, 24'd25600, 16'd1, 16'd1);
        add_ray(24'd0, 24'd0, 16'd3, 16'd2);
        add_ray(24'd0, 24'd0, 16'd38400 / 25600, 16'd1);
        drain();

        // Extreme extents, including saturation of the top or bottom hit.
        write_reg(3'(4 * rrep_pkg::REG_HALF_WIDTH), 32'h7fffff);
        write_reg(3'(4 * rrep_pkg::REG_HALF_HEIGHT), 32'd0);
        add_ray(24'd0, 24'd0, 16'h7fff, 16'd1);
        add_ray(24'd0, 24'd0, 16'h8000, 16'hffff);
        add_ray(24'd0, 24'h7fffff, 16'h7fff, 16'd1);
        add_ray(24'h7fffff, 24'h800000, 16'h8000, 16'h0001);
        repeat (20) add_random_ray();
        drain();

        write_reg(3'(4 * rrep_pkg::REG_HALF_WIDTH), 32'd0);
        write_reg(3'(4 * rrep_pkg::REG_HALF_HEIGHT), 32'hff7fffff);
        repeat (20) add_random_ray();
        drain();

        // Receiver hold-off so the pipeline fills and stalls its input.
        write_reg(3'(4 * rrep_pkg::REG_HALF_WIDTH), 32'd38400);
        write_reg(3'(4 * rrep_pkg::REG_HALF_HEIGHT), 32'd25600);
        hold_cycles = 60;
        repeat (60) add_random_ray();
        drain();

        // Random phases under several extents; the pipeline drains between them.
        for (int p = 0; p < 5; p++)
        begin
            write_reg(3'(4 * rrep_pkg::REG_HALF_WIDTH),
                      $urandom_range(0, 23'h7fffff) >> (p * 4));
            write_reg(3'(4 * rrep_pkg::REG_HALF_HEIGHT),
                      $urandom_range(0, 23'h7fffff) >> (p * 4));
            if (p == 4) calm_phase = 1'b1;
            repeat (110) add_random_ray();
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
